// ===== src/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: phase type, widths and scaling constants.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    localparam int WIDTH_BITS = 16;

    localparam int TRIG_W = 10;
    localparam int TOUT_W = 24;
    localparam int ECHO_W = 16;
    localparam int DIST_W = 14;
    localparam int CFG_W  = 24;

    localparam logic [ECHO_W-1:0] WIDTH_LIMIT =
        (WIDTH_BITS >= ECHO_W) ? {ECHO_W{1'b1}}
                               : ECHO_W'((64'd1 << WIDTH_BITS) - 64'd1);

    localparam logic [TRIG_W-1:0] TRIG_RESET = TRIG_W'(10);
    localparam logic [TOUT_W-1:0] TOUT_RESET = TOUT_W'(1000000);
    localparam logic [TOUT_W-1:0] ELAPSED_MAX = {TOUT_W{1'b1}};

    // distance = floor(width * 343 / 2000), as width * ceil(343 * 2^32 / 2000) >> 32
    localparam int DIST_SHIFT = 32;
    localparam int RECIP_W = 30;
    localparam logic [63:0] RECIP_FULL = ((64'd343 << DIST_SHIFT) + 64'd1999) / 64'd2000;
    localparam logic [RECIP_W-1:0] DIST_RECIP = RECIP_W'(RECIP_FULL);
    localparam int PROD_W = ECHO_W + RECIP_W;

    localparam logic CFG_TRIGGER = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

endpackage

`default_nettype wire

// ===== src/ultrasonic_echo_ranger_top.sv =====
// Ultrasonic echo ranger: tick-driven trigger, echo width counter and distance output.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    start_req, echo_level
// out       output     out_valid / out_ready  trigger_out, done_res, timed_out,
//                                             width_us, distance_mm, busy_res
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// Each input beat is one tick and yields one output beat, registered in the cycle after it is taken.
// A beat is taken every cycle while the output register is empty or draining.
// The width-to-distance multiply sits between the state registers and the output register.
// Reset puts the block idle with trigger_ticks = 10 and timeout_ticks = 1000000.
// A stall on the output holds the result and stops input beats; nothing is lost.

module ultrasonic_echo_ranger_top
    import uer_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                start_req,
    input  wire logic                echo_level,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     trigger_out,
    output logic                     done_res,
    output logic                     timed_out,
    output logic [ECHO_W-1:0]        width_us,
    output logic [DIST_W-1:0]        distance_mm,
    output logic                     busy_res,

    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    phase_t              phase_reg, phase_next;
    logic [TRIG_W-1:0]   trig_cnt_reg, trig_cnt_next;
    logic [ECHO_W-1:0]   echo_cnt_reg, echo_cnt_next;
    logic [TOUT_W-1:0]   elapsed_reg, elapsed_next;
    logic                last_echo_reg, last_echo_next;

    logic [TRIG_W-1:0]   trig_ticks_reg;
    logic [TOUT_W-1:0]   tout_ticks_reg;

    logic                out_valid_reg;
    logic                trigger_reg, trigger_next;
    logic                done_reg, done_next;
    logic                tmo_reg, tmo_next;
    logic [ECHO_W-1:0]   width_reg, width_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic                busy_reg, busy_next;

    logic                accept;
    logic [TRIG_W-1:0]   trig_lim;
    logic [TOUT_W-1:0]   tout_lim;
    logic [PROD_W-1:0]   dist_prod;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign trig_lim = (trig_ticks_reg == '0) ? TRIG_W'(1) : trig_ticks_reg;
    assign tout_lim = (tout_ticks_reg == '0) ? TOUT_W'(1) : tout_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg <= TRIG_RESET;
            tout_ticks_reg <= TOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIGGER: trig_ticks_reg <= cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT: tout_ticks_reg <= cfg_data[TOUT_W-1:0];
                default:     trig_ticks_reg <= trig_ticks_reg;
            endcase
        end
    end

    always_comb
    begin
        logic rise;
        logic fall;
        logic finished;

        rise     = echo_level && !last_echo_reg;
        fall     = !echo_level && last_echo_reg;
        finished = 1'b0;

        phase_next     = phase_reg;
        trig_cnt_next  = trig_cnt_reg;
        echo_cnt_next  = echo_cnt_reg;
        elapsed_next   = elapsed_reg;
        last_echo_next = echo_level;

        trigger_next = 1'b0;
        done_next    = 1'b0;
        tmo_next     = 1'b0;
        width_next   = '0;

        if (phase_reg == PH_IDLE && start_req)
        begin
            phase_next    = PH_TRIG;
            trig_cnt_next = '0;
            elapsed_next  = '0;
            echo_cnt_next = '0;
        end

        if (phase_next != PH_IDLE)
        begin
            if (elapsed_next != ELAPSED_MAX)
            begin
                elapsed_next = elapsed_next + TOUT_W'(1);
            end

            case (phase_next)
                PH_TRIG:
                begin
                    trigger_next  = 1'b1;
                    trig_cnt_next = trig_cnt_next + TRIG_W'(1);
                    if (trig_cnt_next >= trig_lim)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (rise)
                    begin
                        phase_next    = PH_MEAS;
                        echo_cnt_next = ECHO_W'(1);
                    end
                end
                PH_MEAS:
                begin
                    if (fall)
                    begin
                        finished = 1'b1;
                    end
                    else if (echo_level && echo_cnt_next < WIDTH_LIMIT)
                    begin
                        echo_cnt_next = echo_cnt_next + ECHO_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (finished)
            begin
                done_next  = 1'b1;
                width_next = echo_cnt_next;
                phase_next = PH_IDLE;
            end
            else if (elapsed_next >= tout_lim)
            begin
                done_next    = 1'b1;
                tmo_next     = 1'b1;
                trigger_next = 1'b0;
                phase_next   = PH_IDLE;
            end
        end

        busy_next = (phase_next != PH_IDLE);
    end

    assign dist_prod = PROD_W'(width_next) * PROD_W'(DIST_RECIP);
    assign dist_next = dist_prod[DIST_SHIFT +: DIST_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            trig_cnt_reg  <= '0;
            echo_cnt_reg  <= '0;
            elapsed_reg   <= '0;
            last_echo_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            trig_cnt_reg  <= trig_cnt_next;
            echo_cnt_reg  <= echo_cnt_next;
            elapsed_reg   <= elapsed_next;
            last_echo_reg <= last_echo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the beat is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trigger_reg <= trigger_next;
            done_reg    <= done_next;
            tmo_reg     <= tmo_next;
            width_reg   <= width_next;
            dist_reg    <= dist_next;
            busy_reg    <= busy_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign trigger_out = trigger_reg;
    assign done_res    = done_reg;
    assign timed_out   = tmo_reg;
    assign width_us    = width_reg;
    assign distance_mm = dist_reg;
    assign busy_res    = busy_reg;

endmodule

`default_nettype wire
